[hw/rtl/vscg_pkg.sv]
// Package for the vector stroke character generator: types, microcode and glyph tables.
`timescale 1ns / 1ps
`default_nettype none
package vscg_pkg;

   localparam int GLYPH_H     = 94;
   localparam int HALF_W      = 47;
   localparam int NUM_GLYPHS  = 36;
   localparam int NUM_STROKES = 202;
   localparam int PTR_W       = 8;
   localparam int CNT_W       = 4;
   localparam int GIDX_W      = 6;
   localparam int STROKE_W    = 17;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CARET = 8'h5E;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_X_LIMIT    = 3'd0,
      CSR_Y_LIMIT    = 3'd1,
      CSR_LETTER_GAP = 3'd2,
      CSR_WORD_GAP   = 3'd3,
      CSR_LINE_GAP   = 3'd4
   } csr_idx_type;

   // microcode addresses
   typedef enum logic [3:0] {
      U_IDLE, U_START, U_CLASS, U_STROKE, U_LGAP, U_WGAP, U_NL, U_WRAP, U_STAT
   } upc_type;

   typedef enum logic [2:0] {
      A_NOP, A_START, A_LOAD, A_STROKE, A_LGAP, A_WGAP, A_NL, A_WRAP_STAT
   } act_type;

   typedef enum logic [2:0] {
      C_WAIT, C_JUMP, C_SKIP_FULL, C_CLASS, C_LOOP
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
      logic     status;
   } ucode_type;

   // the program: one control word per step
   function automatic ucode_type ucode(input upc_type pc);
      ucode_type w;
      begin
         w = '{act: A_NOP, cond: C_WAIT, target: U_IDLE, status: 1'b0};
         unique case (pc)
            U_IDLE:   w = '{act: A_NOP,    cond: C_WAIT,      target: U_START, status: 1'b0};
            U_START:  w = '{act: A_START,  cond: C_SKIP_FULL, target: U_CLASS, status: 1'b0};
            U_CLASS:  w = '{act: A_LOAD,   cond: C_CLASS,     target: U_WRAP,  status: 1'b0};
            U_STROKE: w = '{act: A_STROKE, cond: C_LOOP,      target: U_LGAP,  status: 1'b0};
            U_LGAP:   w = '{act: A_LGAP,   cond: C_JUMP,      target: U_WRAP,  status: 1'b0};
            U_WGAP:   w = '{act: A_WGAP,   cond: C_JUMP,      target: U_WRAP,  status: 1'b0};
            U_NL:     w = '{act: A_NL,     cond: C_JUMP,      target: U_WRAP,  status: 1'b0};
            U_WRAP:   w = '{act: A_WRAP_STAT, cond: C_JUMP,   target: U_STAT,  status: 1'b0};
            U_STAT:   w = '{act: A_NOP,    cond: C_JUMP,      target: U_IDLE,  status: 1'b1};
            default:  w = '{act: A_NOP,    cond: C_JUMP,      target: U_IDLE,  status: 1'b0};
         endcase
         return w;
      end
   endfunction

   function automatic logic [STROKE_W-1:0] stroke_word(input int p, input int dx, input int dy);
      logic [7:0] bx;
      logic [7:0] by;
      begin
         bx = 8'(dx);
         by = 8'(dy);
         return {1'(p), bx, by};
      end
   endfunction

   // glyph order: '0'..'9', then 'A'..'Z'
   localparam logic [CNT_W-1:0] GLYPH_LEN [NUM_GLYPHS] = '{
      4'd4, 4'd4, 4'd6, 4'd7, 4'd7, 4'd8, 4'd7, 4'd3, 4'd7, 4'd8,
      4'd4, 4'd7, 4'd5, 4'd4, 4'd7, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3, 4'd4,
      4'd5, 4'd4, 4'd5, 4'd7, 4'd7, 4'd7, 4'd5, 4'd4, 4'd5, 4'd7, 4'd4, 4'd7, 4'd5
   };

   localparam logic [PTR_W-1:0] GLYPH_START [NUM_GLYPHS] = '{
      8'd0,   8'd4,   8'd8,   8'd14,  8'd21,  8'd28,  8'd36,  8'd43,  8'd46,  8'd53,
      8'd61,  8'd65,  8'd72,  8'd77,  8'd81,  8'd88,  8'd93,  8'd100, 8'd106, 8'd112,
      8'd119, 8'd123, 8'd126, 8'd130, 8'd135, 8'd139, 8'd144, 8'd151, 8'd158, 8'd165,
      8'd170, 8'd174, 8'd179, 8'd186, 8'd190, 8'd197
   };

   localparam logic [STROKE_W-1:0] GLYPH_ROM [NUM_STROKES] = '{
      // 0
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,94), stroke_word(1,-47,0),
      // 1
      stroke_word(0,23,0), stroke_word(1,0,-94), stroke_word(1,-10,20), stroke_word(0,13,74),
      // 2
      stroke_word(0,0,-70), stroke_word(1,0,-24), stroke_word(1,47,0), stroke_word(1,-47,94),
      stroke_word(1,47,0), stroke_word(1,-47,0),
      // 3
      stroke_word(0,0,-94), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      // 4
      stroke_word(0,0,-47), stroke_word(1,0,-47), stroke_word(1,0,47), stroke_word(1,47,0),
      stroke_word(1,0,-47), stroke_word(1,0,94), stroke_word(0,-47,0),
      // 5
      stroke_word(0,0,-47), stroke_word(1,0,-47), stroke_word(1,47,0), stroke_word(1,-47,0),
      stroke_word(1,0,47), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      // 6
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(0,0,47), stroke_word(1,-47,0),
      stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      // 7
      stroke_word(0,0,-94), stroke_word(1,47,0), stroke_word(1,0,94),
      // 8
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      // 9
      stroke_word(0,0,-47), stroke_word(1,0,-47), stroke_word(1,47,0), stroke_word(1,0,47),
      stroke_word(1,-47,0), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(0,-47,0),
      // A
      stroke_word(1,24,94), stroke_word(1,23,-94), stroke_word(0,0,24), stroke_word(1,-47,0),
      // B
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,94), stroke_word(1,-47,0),
      stroke_word(0,0,-47), stroke_word(1,47,0), stroke_word(0,-47,47),
      // C
      stroke_word(0,47,0), stroke_word(1,-47,0), stroke_word(1,0,-94), stroke_word(1,47,0),
      stroke_word(0,-47,94),
      // D
      stroke_word(1,0,-94), stroke_word(1,37,0), stroke_word(1,0,94), stroke_word(1,-37,0),
      // E
      stroke_word(0,47,0), stroke_word(1,-47,0), stroke_word(1,0,-94), stroke_word(1,47,0),
      stroke_word(0,-47,47), stroke_word(1,-47,0), stroke_word(0,0,47),
      // F
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(0,0,-47), stroke_word(1,-47,0),
      stroke_word(0,-47,-47),
      // G
      stroke_word(0,47,-94), stroke_word(1,-47,0), stroke_word(1,0,94), stroke_word(1,47,0),
      stroke_word(1,0,-9), stroke_word(1,-24,0), stroke_word(0,-23,9),
      // H
      stroke_word(1,0,-94), stroke_word(0,47,0), stroke_word(1,0,94), stroke_word(0,0,-47),
      stroke_word(1,-47,0), stroke_word(0,0,-47),
      // I
      stroke_word(1,47,0), stroke_word(0,0,-94), stroke_word(1,-47,0), stroke_word(0,24,0),
      stroke_word(1,0,94), stroke_word(0,-24,0),
      // J
      stroke_word(0,0,-24), stroke_word(1,0,24), stroke_word(1,24,0), stroke_word(1,0,-94),
      stroke_word(0,-24,0), stroke_word(1,47,0), stroke_word(0,-47,94),
      // K
      stroke_word(1,0,94), stroke_word(0,47,0), stroke_word(1,-47,47), stroke_word(1,47,47),
      // L
      stroke_word(0,0,-94), stroke_word(1,0,94), stroke_word(1,47,0),
      // M
      stroke_word(1,0,-94), stroke_word(1,24,47), stroke_word(1,23,-47), stroke_word(1,-47,94),
      // N
      stroke_word(1,0,-94), stroke_word(1,47,94), stroke_word(1,0,-94), stroke_word(0,-47,0),
      stroke_word(0,0,94),
      // O
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,94), stroke_word(1,-47,0),
      // P
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      stroke_word(1,0,47),
      // Q
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,94), stroke_word(1,-47,0),
      stroke_word(1,0,-94), stroke_word(1,47,94), stroke_word(1,-47,0),
      // R
      stroke_word(1,0,-94), stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-35,0),
      stroke_word(1,35,35), stroke_word(1,0,12), stroke_word(0,-47,0),
      // S
      stroke_word(0,0,-47), stroke_word(1,0,-47), stroke_word(1,47,0), stroke_word(0,-47,47),
      stroke_word(1,47,0), stroke_word(1,0,47), stroke_word(1,-47,0),
      // T
      stroke_word(0,0,-94), stroke_word(1,47,0), stroke_word(1,-23,0), stroke_word(1,0,94),
      stroke_word(0,-23,0),
      // U
      stroke_word(1,0,-94), stroke_word(0,47,0), stroke_word(1,0,94), stroke_word(1,-47,0),
      // V
      stroke_word(0,0,-94), stroke_word(1,23,94), stroke_word(1,46,-94), stroke_word(0,-46,0),
      stroke_word(0,0,94),
      // W
      stroke_word(0,0,-94), stroke_word(1,11,94), stroke_word(1,22,-47), stroke_word(1,33,47),
      stroke_word(1,44,-94), stroke_word(0,-44,0), stroke_word(0,0,94),
      // X
      stroke_word(0,0,-94), stroke_word(1,47,94), stroke_word(0,0,-94), stroke_word(1,-47,94),
      // Y
      stroke_word(0,23,0), stroke_word(1,0,-47), stroke_word(1,-23,-47), stroke_word(0,46,0),
      stroke_word(1,-23,47), stroke_word(1,0,47), stroke_word(0,-23,0),
      // Z
      stroke_word(0,0,-94), stroke_word(1,47,0), stroke_word(1,-47,94), stroke_word(1,47,0),
      stroke_word(1,-47,0)
   };

endpackage
`default_nettype wire

[hw/rtl/vector_stroke_char_generator_core.sv]
// Vector stroke character generator: microcoded sequencer emitting pen moves per text byte.
// Steps per byte: start, class, one stroke step per stroke of the glyph (up to 8) and a
//   letter gap, or one word-gap or newline step for a space or caret, then wrap and status;
//   a full grid skips from start to status unless the byte starts the text. One microcode step
//   per cycle while the output is not stalled, at most one registered result per step.
// Output stalls hold the sequencer on its current step.
// Reset (synchronous, active high): cursors at 0, grid not full, limits 32767, gaps 70/94/50.
`timescale 1ns / 1ps
`default_nettype none
module vector_stroke_char_generator_core #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_char_code,
   input  wire logic                      req_start_of_text,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_kind,
   output logic                           rsp_pen_down,
   output logic signed [15:0]             rsp_target_x,
   output logic signed [15:0]             rsp_target_y,
   output logic                           rsp_grid_full,
   output logic                           rsp_last,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire vscg_pkg::csr_idx_type     csr_index,
   input  wire logic [14:0]               csr_wdata
);
   import vscg_pkg::*;

   localparam int CW = COORD_WIDTH;

   upc_type               upc_ff, upc_in;
   logic [7:0]            char_ff, char_in;
   logic                  sot_ff, sot_in;
   logic [CW-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic                  full_ff, full_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [14:0]           x_limit_ff, y_limit_ff;
   logic [9:0]            letter_gap_ff, word_gap_ff, line_gap_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff, kind_in, pen_ff, pen_in, gfull_ff, gfull_in, last_ff, last_in;
   logic [15:0]           tx_ff, tx_in, ty_ff, ty_in;

   ucode_type             cw;
   logic                  go, accept, emit;
   logic [7:0]            folded;
   logic                  is_digit, is_alpha, is_glyph;
   logic [GIDX_W-1:0]     gidx;
   logic [STROKE_W-1:0]   stroke;
   logic                  x_hit, y_hit;
   logic [CW+15:0]        ext_x, ext_y;

   assign cw        = ucode(upc_ff);
   assign req_stall = (upc_ff != U_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign go        = (upc_ff != U_IDLE) & ~(rsp_valid_ff & rsp_stall);
   assign csr_ready = 1'b1;

   // character classification, lower case folded
   always_comb begin
      folded = char_ff;
      if (char_ff >= 8'h61 && char_ff <= 8'h7A) begin
         folded = char_ff - 8'd32;
      end
      is_digit = (folded >= 8'h30) && (folded <= 8'h39);
      is_alpha = (folded >= 8'h41) && (folded <= 8'h5A);
      is_glyph = is_digit | is_alpha;
      gidx     = '0;
      if (is_digit) begin
         gidx = GIDX_W'(folded - 8'h30);
      end else if (is_alpha) begin
         gidx = GIDX_W'(folded - 8'h41 + 8'd10);
      end
   end

   assign stroke = GLYPH_ROM[ptr_ff];

   // signed compares against x_limit-47 and y_limit
   assign x_hit = $signed({{(34-CW){cx_ff[CW-1]}}, cx_ff}) >=
                  ($signed({19'b0, x_limit_ff}) - 34'sd47);
   assign y_hit = $signed({{(34-CW){cy_ff[CW-1]}}, cy_ff}) >= $signed({19'b0, y_limit_ff});

   always_comb begin
      upc_in   = upc_ff;
      char_in  = char_ff;
      sot_in   = sot_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      full_in  = full_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      kind_in  = 1'b0;
      pen_in   = 1'b0;
      gfull_in = 1'b0;
      last_in  = 1'b0;

      if (accept) begin
         char_in = req_char_code;
         sot_in  = req_start_of_text;
         upc_in  = U_START;
      end

      if (go) begin
         unique case (cw.act)
            A_START: begin
               if (sot_ff) begin
                  full_in = 1'b0;
                  cy_in   = cy_ff + CW'(GLYPH_H);
                  emit    = 1'b1;
               end
            end
            A_LOAD: begin
               ptr_in = GLYPH_START[gidx];
               cnt_in = GLYPH_LEN[gidx];
            end
            A_STROKE: begin
               cx_in  = cx_ff + {{(CW-8){stroke[15]}}, stroke[15:8]};
               cy_in  = cy_ff + {{(CW-8){stroke[7]}}, stroke[7:0]};
               pen_in = stroke[16];
               ptr_in = ptr_ff + PTR_W'(1);
               cnt_in = cnt_ff - CNT_W'(1);
               emit   = 1'b1;
            end
            A_LGAP: begin
               cx_in = cx_ff + {{(CW-10){1'b0}}, letter_gap_ff};
               emit  = 1'b1;
            end
            A_WGAP: begin
               cx_in = cx_ff + {{(CW-10){1'b0}}, word_gap_ff};
               emit  = 1'b1;
            end
            A_NL: begin
               cx_in = '0;
               cy_in = cy_ff + CW'(GLYPH_H) + {{(CW-10){1'b0}}, line_gap_ff};
               emit  = 1'b1;
            end
            A_WRAP_STAT: begin
               if (x_hit && y_hit) begin
                  full_in = 1'b1;
               end else if (x_hit) begin
                  cx_in = '0;
                  cy_in = cy_ff + CW'(GLYPH_H) + {{(CW-10){1'b0}}, line_gap_ff};
                  emit  = 1'b1;
               end
            end
            A_NOP: begin
               if (cw.status) begin
                  kind_in  = 1'b1;
                  gfull_in = full_ff;
                  last_in  = 1'b1;
                  emit     = 1'b1;
               end
            end
            default: begin
            end
         endcase

         unique case (cw.cond)
            C_JUMP: upc_in = cw.target;
            C_SKIP_FULL: upc_in = (!sot_ff && full_ff) ? U_STAT : cw.target;
            C_CLASS: begin
               priority if (is_glyph) begin
                  upc_in = U_STROKE;
               end else if (folded == CHAR_SPACE) begin
                  upc_in = U_WGAP;
               end else if (folded == CHAR_CARET) begin
                  upc_in = U_NL;
               end else begin
                  upc_in = cw.target;
               end
            end
            C_LOOP: upc_in = (cnt_ff > CNT_W'(1)) ? U_STROKE : cw.target;
            C_WAIT: upc_in = upc_ff;
            default: upc_in = U_IDLE;
         endcase
      end
   end

   // result payload carries the low 16 bits of the updated cursor
   assign ext_x = {16'b0, cx_in};
   assign ext_y = {16'b0, cy_in};
   assign tx_in = ext_x[15:0];
   assign ty_in = ext_y[15:0];

   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= U_IDLE;
         cx_ff         <= '0;
         cy_ff         <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         x_limit_ff    <= 15'd32767;
         y_limit_ff    <= 15'd32767;
         letter_gap_ff <= 10'd70;
         word_gap_ff   <= 10'd94;
         line_gap_ff   <= 10'd50;
      end else begin
         upc_ff       <= upc_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_X_LIMIT:    x_limit_ff    <= csr_wdata;
               CSR_Y_LIMIT:    y_limit_ff    <= csr_wdata;
               CSR_LETTER_GAP: letter_gap_ff <= csr_wdata[9:0];
               CSR_WORD_GAP:   word_gap_ff   <= csr_wdata[9:0];
               CSR_LINE_GAP:   line_gap_ff   <= csr_wdata[9:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      sot_ff  <= sot_in;
      ptr_ff  <= ptr_in;
      cnt_ff  <= cnt_in;
      if (emit) begin
         kind_ff  <= kind_in;
         pen_ff   <= pen_in;
         gfull_ff <= gfull_in;
         last_ff  <= last_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_pen_down  = pen_ff;
   assign rsp_grid_full = gfull_ff;
   assign rsp_last      = last_ff;
   assign rsp_target_x  = $signed(tx_ff);
   assign rsp_target_y  = $signed(ty_ff);

`ifndef SYNTHESIS
   a_stroke_count: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_STROKE) |-> (cnt_ff != '0))
      else $error("stroke step with zero count");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff) |-> last_ff)
      else $error("status result not marked last");

   a_stat_to_idle: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_STAT && go) |=> (upc_ff == U_IDLE))
      else $error("sequencer did not return to idle after status");

   a_no_emit_over: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !emit)
      else $error("result issued over a stalled result");
`endif

endmodule
`default_nettype wire
